[hdl/rre_pkg.sv]
// ----------------------------------------------------------------------------
// rre_pkg
// Shared types and constants of the rectangle raster engine: canvas sizes,
// action and register codes, controller states and the command and status
// bundles between controller and datapath.
// ----------------------------------------------------------------------------
package rre_pkg;

    localparam int MAX_SIDE  = 256;
    localparam int SIDE_W    = $clog2(MAX_SIDE);
    localparam int ADDR_W    = 2 * SIDE_W;
    localparam int MEM_DEPTH = MAX_SIDE * MAX_SIDE;

    localparam int CANVAS_W  = 9;   // canvas_width / canvas_height register width
    localparam int CHAR_W    = 8;
    localparam int RECT_W    = 9;
    localparam int POS_W     = 10;
    localparam int COORD_W   = 12;  // signed room for pos - 1 + size - 1
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;

    localparam logic [CANVAS_W-1:0] CANVAS_RST = CANVAS_W'(MAX_SIDE);
    localparam logic [CHAR_W-1:0]   BG_RST     = 8'd32;

    // actions
    localparam logic [1:0] ACT_CLEAR = 2'd0;
    localparam logic [1:0] ACT_DRAW  = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CANVAS_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BACKGROUND    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BOUNDS,
        ST_CLIP,
        ST_WALK,
        ST_READ,
        ST_RESP
    } t_state;

    typedef struct packed {
        logic load;      // capture the input beat
        logic bounds;    // form rectangle corners
        logic clip;      // clip to the canvas, start the walk
        logic step;      // visit one pixel, write it if filled or border
        logic rd_issue;  // read the canvas
        logic out_load;  // load the output register
    } t_cmd;

    typedef struct packed {
        logic empty;     // clipped area holds no pixel
        logic last;      // walk sits on the final pixel
        logic out_free;  // output register can take a result
    } t_stat;

endpackage

[hdl/rectangle_raster_engine.sv]
// ----------------------------------------------------------------------------
// rectangle_raster_engine
// Character canvas with clear, filled or outline rectangle draw, and single
// pixel read.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+---------------------------
//   in      | to block  | i_in_valid / o_in_ready   | action, filled, sizes,
//           |           |                           | position, char, read pos
//   out     | from block| o_out_valid / i_out_ready | pixel_char (reads only)
//   cfg     | to block  | i_cfg_valid / o_cfg_ready | index, data
//
// Clear and draw form the corners, clip them to the canvas, then walk the
// clipped area unless empty; a read fetches a pixel for the output register.
// The single write port of the canvas memory sets the one pixel per cycle walk.
// Reset clears control and configuration only; the canvas holds garbage until
// the first clear.
// A stalled output holds the result; clears and draws still proceed, a read
// waits for the output register.
// ----------------------------------------------------------------------------
module rectangle_raster_engine (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic [1:0]                        i_action,
    input  logic                              i_filled,
    input  logic [rre_pkg::RECT_W-1:0]        i_rect_width,
    input  logic [rre_pkg::RECT_W-1:0]        i_rect_height,
    input  logic signed [rre_pkg::POS_W-1:0]  i_pos_left,
    input  logic signed [rre_pkg::POS_W-1:0]  i_pos_top,
    input  logic [rre_pkg::CHAR_W-1:0]        i_draw_char,
    input  logic [rre_pkg::SIDE_W-1:0]        i_read_col,
    input  logic [rre_pkg::SIDE_W-1:0]        i_read_row,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic [rre_pkg::CHAR_W-1:0]        o_pixel_char,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [rre_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rre_pkg::CFG_DAT_W-1:0]     i_cfg_data
);

    rre_pkg::t_cmd  cmd;
    rre_pkg::t_stat stat;

    assign o_cfg_ready = 1'b1;

    rre_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_action   (i_action),
        .o_in_ready (o_in_ready),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    rre_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_action      (i_action),
        .i_filled      (i_filled),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_pos_left    (i_pos_left),
        .i_pos_top     (i_pos_top),
        .i_draw_char   (i_draw_char),
        .i_read_col    (i_read_col),
        .i_read_row    (i_read_row),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_pixel_char  (o_pixel_char)
    );

endmodule

[hdl/rre_ctrl.sv]
// ----------------------------------------------------------------------------
// rre_ctrl
// Controller of the rectangle raster engine: sequences clear, draw and read
// commands over the datapath.
// ----------------------------------------------------------------------------
module rre_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic [1:0]    i_action,
    output logic          o_in_ready,
    input  rre_pkg::t_stat i_stat,
    output rre_pkg::t_cmd  o_cmd
);

    rre_pkg::t_state r_state;
    rre_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rre_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            rre_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    case (i_action)
                        rre_pkg::ACT_CLEAR,
                        rre_pkg::ACT_DRAW: n_state = rre_pkg::ST_BOUNDS;
                        rre_pkg::ACT_READ: n_state = rre_pkg::ST_READ;
                        default:           n_state = rre_pkg::ST_IDLE;
                    endcase
                end
            end
            rre_pkg::ST_BOUNDS: begin
                o_cmd.bounds = 1'b1;
                n_state      = rre_pkg::ST_CLIP;
            end
            rre_pkg::ST_CLIP: begin
                o_cmd.clip = 1'b1;
                n_state    = rre_pkg::ST_WALK;
            end
            rre_pkg::ST_WALK: begin
                // drop straight out when nothing survives clipping
                if (i_stat.empty) begin
                    n_state = rre_pkg::ST_IDLE;
                end else begin
                    o_cmd.step = 1'b1;
                    if (i_stat.last) begin
                        n_state = rre_pkg::ST_IDLE;
                    end
                end
            end
            rre_pkg::ST_READ: begin
                o_cmd.rd_issue = 1'b1;
                n_state        = rre_pkg::ST_RESP;
            end
            rre_pkg::ST_RESP: begin
                // hold the read data until the output register frees up
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = rre_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = rre_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

[hdl/rre_dp.sv]
// ----------------------------------------------------------------------------
// rre_dp
// Datapath of the rectangle raster engine: configuration registers, command
// capture, rectangle bounds and clipping, pixel walk counters, the canvas
// memory and the output register.
// ----------------------------------------------------------------------------
module rre_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  rre_pkg::t_cmd                     i_cmd,
    output rre_pkg::t_stat                    o_stat,
    input  logic                              i_cfg_valid,
    input  logic [rre_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [rre_pkg::CFG_DAT_W-1:0]     i_cfg_data,
    input  logic [1:0]                        i_action,
    input  logic                              i_filled,
    input  logic [rre_pkg::RECT_W-1:0]        i_rect_width,
    input  logic [rre_pkg::RECT_W-1:0]        i_rect_height,
    input  logic signed [rre_pkg::POS_W-1:0]  i_pos_left,
    input  logic signed [rre_pkg::POS_W-1:0]  i_pos_top,
    input  logic [rre_pkg::CHAR_W-1:0]        i_draw_char,
    input  logic [rre_pkg::SIDE_W-1:0]        i_read_col,
    input  logic [rre_pkg::SIDE_W-1:0]        i_read_row,
    input  logic                              i_out_ready,
    output logic                              o_out_valid,
    output logic [rre_pkg::CHAR_W-1:0]        o_pixel_char
);

    localparam int CW = rre_pkg::COORD_W;
    localparam int SW = rre_pkg::SIDE_W;

    // configuration
    logic [rre_pkg::CANVAS_W-1:0] r_cfg_w;
    logic [rre_pkg::CANVAS_W-1:0] r_cfg_h;
    logic [rre_pkg::CHAR_W-1:0]   r_bg;

    // captured command
    logic                         r_clear;
    logic                         r_fill;
    logic [rre_pkg::RECT_W-1:0]   r_w;
    logic [rre_pkg::RECT_W-1:0]   r_h;
    logic signed [rre_pkg::POS_W-1:0] r_left;
    logic signed [rre_pkg::POS_W-1:0] r_top;
    logic [rre_pkg::CHAR_W-1:0]   r_char;
    logic [SW-1:0]                r_rcol;
    logic [SW-1:0]                r_rrow;

    // rectangle corners and clipped bounds
    logic signed [CW-1:0] r_x0, r_x1, r_y0, r_y1;
    logic signed [CW-1:0] r_cs, r_ce, r_rs, r_re;
    logic signed [CW-1:0] n_x0, n_x1, n_y0, n_y1;
    logic signed [CW-1:0] n_cs, n_ce, n_rs, n_re;

    // walk counters
    logic [SW-1:0] r_walk_col;
    logic [SW-1:0] r_walk_row;

    // canvas and read path
    logic [rre_pkg::CHAR_W-1:0]   r_canvas [rre_pkg::MEM_DEPTH];
    logic [rre_pkg::CHAR_W-1:0]   r_rdata;
    logic                         r_rd_bg;
    logic                         r_out_valid;
    logic [rre_pkg::CHAR_W-1:0]   r_pixel;

    logic [rre_pkg::CANVAS_W-1:0] cw_use;
    logic [rre_pkg::CANVAS_W-1:0] ch_use;
    logic signed [CW-1:0]         cw_m1;
    logic signed [CW-1:0]         ch_m1;
    logic signed [CW-1:0]         col_s;
    logic signed [CW-1:0]         row_s;
    logic                         col_end;
    logic                         border;
    logic                         we;

    // registers above the largest side act as the largest side
    assign cw_use = (r_cfg_w > rre_pkg::CANVAS_RST) ? rre_pkg::CANVAS_RST : r_cfg_w;
    assign ch_use = (r_cfg_h > rre_pkg::CANVAS_RST) ? rre_pkg::CANVAS_RST : r_cfg_h;
    assign cw_m1  = $signed(CW'(cw_use)) - CW'(1);
    assign ch_m1  = $signed(CW'(ch_use)) - CW'(1);

    always_comb begin
        if (r_clear) begin
            n_x0 = '0;
            n_x1 = cw_m1;
            n_y0 = '0;
            n_y1 = ch_m1;
        end else begin
            n_x0 = CW'(r_left) - CW'(1);
            n_x1 = CW'(r_left) + $signed(CW'(r_w)) - CW'(2);
            n_y0 = CW'(r_top) - CW'(1);
            n_y1 = CW'(r_top) + $signed(CW'(r_h)) - CW'(2);
        end
    end

    // a zero size, a zero canvas or an off-canvas rectangle leaves start past end
    assign n_cs = (r_x0 < 0) ? '0 : r_x0;
    assign n_ce = (r_x1 < cw_m1) ? r_x1 : cw_m1;
    assign n_rs = (r_y0 < 0) ? '0 : r_y0;
    assign n_re = (r_y1 < ch_m1) ? r_y1 : ch_m1;

    assign col_s   = $signed(CW'(r_walk_col));
    assign row_s   = $signed(CW'(r_walk_row));
    assign col_end = (r_walk_col == r_ce[SW-1:0]);
    assign border  = (col_s == r_x0) || (col_s == r_x1) || (row_s == r_y0) || (row_s == r_y1);
    assign we      = i_cmd.step && (r_fill || border);

    assign o_stat.empty    = (r_cs > r_ce) || (r_rs > r_re);
    assign o_stat.last     = col_end && (r_walk_row == r_re[SW-1:0]);
    assign o_stat.out_free = !r_out_valid || i_out_ready;

    assign o_out_valid  = r_out_valid;
    assign o_pixel_char = r_pixel;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w     <= rre_pkg::CANVAS_RST;
            r_cfg_h     <= rre_pkg::CANVAS_RST;
            r_bg        <= rre_pkg::BG_RST;
            r_walk_col  <= '0;
            r_walk_row  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    rre_pkg::CFG_CANVAS_WIDTH:  r_cfg_w <= i_cfg_data;
                    rre_pkg::CFG_CANVAS_HEIGHT: r_cfg_h <= i_cfg_data;
                    rre_pkg::CFG_BACKGROUND:    r_bg    <= i_cfg_data[rre_pkg::CHAR_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.clip) begin
                r_walk_col <= n_cs[SW-1:0];
                r_walk_row <= n_rs[SW-1:0];
            end else if (i_cmd.step) begin
                if (o_stat.last) begin
                    r_walk_col <= '0;
                    r_walk_row <= '0;
                end else if (col_end) begin
                    r_walk_col <= r_cs[SW-1:0];
                    r_walk_row <= r_walk_row + SW'(1);
                end else begin
                    r_walk_col <= r_walk_col + SW'(1);
                end
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_clear <= (i_action == rre_pkg::ACT_CLEAR);
            r_fill  <= (i_action == rre_pkg::ACT_CLEAR) || i_filled;
            r_char  <= (i_action == rre_pkg::ACT_CLEAR) ? r_bg : i_draw_char;
            r_w     <= i_rect_width;
            r_h     <= i_rect_height;
            r_left  <= i_pos_left;
            r_top   <= i_pos_top;
            r_rcol  <= i_read_col;
            r_rrow  <= i_read_row;
        end
        if (i_cmd.bounds) begin
            r_x0 <= n_x0;
            r_x1 <= n_x1;
            r_y0 <= n_y0;
            r_y1 <= n_y1;
        end
        if (i_cmd.clip) begin
            r_cs <= n_cs;
            r_ce <= n_ce;
            r_rs <= n_rs;
            r_re <= n_re;
        end
        if (i_cmd.rd_issue) begin
            r_rd_bg <= (CW'(r_rcol) >= CW'(cw_use)) || (CW'(r_rrow) >= CW'(ch_use));
        end
        if (i_cmd.out_load) begin
            r_pixel <= r_rd_bg ? r_bg : r_rdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_canvas[{r_walk_row, r_walk_col}] <= r_char;
        end
        if (i_cmd.rd_issue) begin
            r_rdata <= r_canvas[{r_rrow, r_rcol}];
        end
    end

endmodule

[hdl/rre_checker.sv]
// ----------------------------------------------------------------------------
// rre_checker
// Port-level checks of the rectangle raster engine, bound to the top level.
// ----------------------------------------------------------------------------
module rre_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_ready,
    input logic [1:0]                 i_action,
    input logic                       o_out_valid,
    input logic                       i_out_ready,
    input logic [rre_pkg::CHAR_W-1:0] o_pixel_char
);

    // a result waits until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_pixel_char))
        else $error("output beat dropped or changed while stalled");

    // a read keeps the input side busy while it fetches
    a_read_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_action == rre_pkg::ACT_READ)
        |=> !o_in_ready ##1 !o_in_ready)
        else $error("input accepted during a read");

    // clear and draw pass through bounds, clip and the walk before the input frees
    a_draw_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready
        && ((i_action == rre_pkg::ACT_CLEAR) || (i_action == rre_pkg::ACT_DRAW))
        |=> !o_in_ready ##1 !o_in_ready ##1 !o_in_ready)
        else $error("input accepted during a clear or draw");

    // the unused action code is dropped at once
    a_noop_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_ready && (i_action != rre_pkg::ACT_CLEAR)
        && (i_action != rre_pkg::ACT_DRAW) && (i_action != rre_pkg::ACT_READ)
        |=> o_in_ready)
        else $error("unused action held the block");

endmodule

bind rectangle_raster_engine rre_checker u_rre_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_in_valid),
    .o_in_ready   (o_in_ready),
    .i_action     (i_action),
    .o_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .o_pixel_char (o_pixel_char)
);

[tb/sv/rectangle_raster_engine_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rectangle_raster_engine_tb
// Self-checking bench for the character canvas engine. A shadow canvas in the
// bench follows every accepted clear, draw and read and queues the character
// each read must return. Reset defaults and edge cases are exercised first,
// then random traffic over a range of canvas sizes, including empty,
// minimal and oversize settings, with random idling on both channels and one
// long output stall.
// ----------------------------------------------------------------------------
module rectangle_raster_engine_tb;

    localparam logic [1:0]                    ACT_NONE      = 2'd3;  // unused action code
    localparam logic [rre_pkg::CFG_IDX_W-1:0] CFG_SPARE     = 2'd3;  // unused register index
    localparam logic [rre_pkg::CHAR_W-1:0]    CHAR_R        = "R";
    localparam int                            WIDE_RECT     = 300;
    localparam int                            IDLE_PCT      = 13;
    localparam int                            HOLD_CYCLES   = 400;
    localparam int                            SETTLE_CYCLES = 16;
    // stimulus includes full-canvas clears and one full-canvas draw at 256 x 256
    localparam int                            CYCLE_LIMIT   = 4_000_000;

    typedef struct {
        logic [1:0]                        action;
        logic                              filled;
        logic [rre_pkg::RECT_W-1:0]        rect_w;
        logic [rre_pkg::RECT_W-1:0]        rect_h;
        logic signed [rre_pkg::POS_W-1:0]  pos_left;
        logic signed [rre_pkg::POS_W-1:0]  pos_top;
        logic [rre_pkg::CHAR_W-1:0]        draw_char;
        logic [rre_pkg::SIDE_W-1:0]        read_col;
        logic [rre_pkg::SIDE_W-1:0]        read_row;
    } t_command;

    logic                                 i_clk         = 1'b0;
    logic                                 i_rst_n       = 1'b0;
    logic                                 i_in_valid    = 1'b0;
    logic                                 o_in_ready;
    logic [1:0]                           i_action      = '0;
    logic                                 i_filled      = 1'b0;
    logic [rre_pkg::RECT_W-1:0]           i_rect_width  = '0;
    logic [rre_pkg::RECT_W-1:0]           i_rect_height = '0;
    logic signed [rre_pkg::POS_W-1:0]     i_pos_left    = '0;
    logic signed [rre_pkg::POS_W-1:0]     i_pos_top     = '0;
    logic [rre_pkg::CHAR_W-1:0]           i_draw_char   = '0;
    logic [rre_pkg::SIDE_W-1:0]           i_read_col    = '0;
    logic [rre_pkg::SIDE_W-1:0]           i_read_row    = '0;
    logic                                 o_out_valid;
    logic                                 i_out_ready   = 1'b0;
    logic [rre_pkg::CHAR_W-1:0]           o_pixel_char;
    logic                                 i_cfg_valid   = 1'b0;
    logic                                 o_cfg_ready;
    logic [rre_pkg::CFG_IDX_W-1:0]        i_cfg_index   = '0;
    logic [rre_pkg::CFG_DAT_W-1:0]        i_cfg_data    = '0;

    // shadow of the block
    logic [rre_pkg::CHAR_W-1:0]   shadow_canvas [0:rre_pkg::MEM_DEPTH-1];
    logic [rre_pkg::CANVAS_W-1:0] shadow_width  = rre_pkg::CANVAS_RST;
    logic [rre_pkg::CANVAS_W-1:0] shadow_height = rre_pkg::CANVAS_RST;
    logic [rre_pkg::CHAR_W-1:0]   shadow_bg     = rre_pkg::BG_RST;
    logic [rre_pkg::CHAR_W-1:0]   pixel_expect_q [$];

    int  cycle_count    = 0;
    int  mismatch_count = 0;
    int  pixels_checked = 0;
    int  clears_sent    = 0;
    int  draws_sent     = 0;
    int  reads_sent     = 0;
    int  cfg_writes     = 0;
    bit  steady         = 1'b0;
    bit  hold_req       = 1'b0;
    logic [rre_pkg::CHAR_W-1:0] pixel_want;

    rectangle_raster_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_filled      (i_filled),
        .i_rect_width  (i_rect_width),
        .i_rect_height (i_rect_height),
        .i_pos_left    (i_pos_left),
        .i_pos_top     (i_pos_top),
        .i_draw_char   (i_draw_char),
        .i_read_col    (i_read_col),
        .i_read_row    (i_read_row),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_pixel_char  (o_pixel_char),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // shadow model
    // ------------------------------------------------------------------
    function automatic int side_used(input logic [rre_pkg::CANVAS_W-1:0] v);
        return (v > rre_pkg::MAX_SIDE) ? rre_pkg::MAX_SIDE : int'(v);
    endfunction

    function automatic void shadow_config(input logic [rre_pkg::CFG_IDX_W-1:0] idx,
                                          input logic [rre_pkg::CFG_DAT_W-1:0] val);
        cfg_writes++;
        case (idx)
            rre_pkg::CFG_CANVAS_WIDTH:  shadow_width  = val;
            rre_pkg::CFG_CANVAS_HEIGHT: shadow_height = val;
            rre_pkg::CFG_BACKGROUND:    shadow_bg     = val[rre_pkg::CHAR_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void shadow_apply(input t_command cmd);
        int  cw, ch, x0, y0, x1, y1, r, c;
        bit  border;
        cw = side_used(shadow_width);
        ch = side_used(shadow_height);
        case (cmd.action)
            rre_pkg::ACT_CLEAR: begin
                clears_sent++;
                for (r = 0; r < ch; r++)
                    for (c = 0; c < cw; c++)
                        shadow_canvas[r * rre_pkg::MAX_SIDE + c] = shadow_bg;
            end
            rre_pkg::ACT_DRAW: begin
                draws_sent++;
                x0 = int'(cmd.pos_left) - 1;
                y0 = int'(cmd.pos_top) - 1;
                x1 = x0 + int'(cmd.rect_w) - 1;
                y1 = y0 + int'(cmd.rect_h) - 1;
                if (cmd.rect_w != 0 && cmd.rect_h != 0) begin
                    for (r = (y0 < 0) ? 0 : y0; r <= y1 && r < ch; r++) begin
                        for (c = (x0 < 0) ? 0 : x0; c <= x1 && c < cw; c++) begin
                            border = (c == x0) || (c == x1) || (r == y0) || (r == y1);
                            if (cmd.filled || border)
                                shadow_canvas[r * rre_pkg::MAX_SIDE + c] = cmd.draw_char;
                        end
                    end
                end
            end
            rre_pkg::ACT_READ: begin
                reads_sent++;
                if (int'(cmd.read_col) >= cw || int'(cmd.read_row) >= ch)
                    pixel_expect_q.push_back(shadow_bg);
                else
                    pixel_expect_q.push_back(
                        shadow_canvas[int'(cmd.read_row) * rre_pkg::MAX_SIDE
                                      + int'(cmd.read_col)]);
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_command rand_command(input int clear_pct, input int big_pct);
        t_command cmd;
        int cw, ch, pick, x, y;
        cw = side_used(shadow_width);
        ch = side_used(shadow_height);
        cmd.action    = ACT_NONE;
        cmd.filled    = 1'($urandom);
        cmd.rect_w    = rre_pkg::RECT_W'($urandom);
        cmd.rect_h    = rre_pkg::RECT_W'($urandom);
        cmd.pos_left  = rre_pkg::POS_W'($urandom);
        cmd.pos_top   = rre_pkg::POS_W'($urandom);
        cmd.draw_char = rre_pkg::CHAR_W'($urandom);
        cmd.read_col  = rre_pkg::SIDE_W'($urandom);
        cmd.read_row  = rre_pkg::SIDE_W'($urandom);
        pick = $urandom_range(99);
        if (pick < clear_pct) begin
            cmd.action = rre_pkg::ACT_CLEAR;
        end else if (pick < clear_pct + 4) begin
            cmd.action = ACT_NONE;
        end else if (pick < 52) begin
            cmd.action = rre_pkg::ACT_DRAW;
            // keep most rectangles small, the walk visits every pixel of the clipped area
            if ($urandom_range(99) >= big_pct) begin
                cmd.rect_w = rre_pkg::RECT_W'($urandom_range(0, 16));
                cmd.rect_h = rre_pkg::RECT_W'($urandom_range(0, 16));
            end
            // place most rectangles on or around the canvas
            if ($urandom_range(9) != 0) begin
                x = int'($urandom_range(0, cw + 1)) - int'($urandom_range(0, cmd.rect_w));
                y = int'($urandom_range(0, ch + 1)) - int'($urandom_range(0, cmd.rect_h));
                cmd.pos_left = rre_pkg::POS_W'(x + 1);
                cmd.pos_top  = rre_pkg::POS_W'(y + 1);
            end
        end else begin
            cmd.action = rre_pkg::ACT_READ;
            if (cw > 0 && ch > 0 && $urandom_range(9) < 8) begin
                cmd.read_col = rre_pkg::SIDE_W'($urandom_range(0, cw - 1));
                cmd.read_row = rre_pkg::SIDE_W'($urandom_range(0, ch - 1));
            end
        end
        return cmd;
    endfunction

    function automatic t_command as_action(input t_command cmd, input logic [1:0] act);
        cmd.action = act;
        return cmd;
    endfunction

    function automatic t_command make_draw(input bit fill, input int l, input int t,
                                           input int w, input int h,
                                           input logic [rre_pkg::CHAR_W-1:0] chr);
        t_command cmd;
        cmd = as_action(rand_command(0, 0), rre_pkg::ACT_DRAW);
        cmd.filled    = fill;
        cmd.pos_left  = rre_pkg::POS_W'(l);
        cmd.pos_top   = rre_pkg::POS_W'(t);
        cmd.rect_w    = rre_pkg::RECT_W'(w);
        cmd.rect_h    = rre_pkg::RECT_W'(h);
        cmd.draw_char = chr;
        return cmd;
    endfunction

    function automatic t_command make_read(input int col, input int row);
        t_command cmd;
        cmd = as_action(rand_command(0, 0), rre_pkg::ACT_READ);
        cmd.read_col = rre_pkg::SIDE_W'(col);
        cmd.read_row = rre_pkg::SIDE_W'(row);
        return cmd;
    endfunction

    function automatic int idle_gap();
        if (steady || $urandom_range(99) >= IDLE_PCT)
            return 0;
        return $urandom_range(1, 4);
    endfunction

    // offer one beat, hold it until taken, then update the shadow
    task automatic send_command(input t_command cmd);
        int gap;
        gap = idle_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_action      <= cmd.action;
        i_filled      <= cmd.filled;
        i_rect_width  <= cmd.rect_w;
        i_rect_height <= cmd.rect_h;
        i_pos_left    <= cmd.pos_left;
        i_pos_top     <= cmd.pos_top;
        i_draw_char   <= cmd.draw_char;
        i_read_col    <= cmd.read_col;
        i_read_row    <= cmd.read_row;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        shadow_apply(cmd);
    endtask

    task automatic release_input();
        i_in_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pixel_expect_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic program_canvas(input int width, input int height, input int bg);
        logic [rre_pkg::CFG_IDX_W-1:0] idx [4];
        logic [rre_pkg::CFG_DAT_W-1:0] val [4];
        int k;
        idx = '{rre_pkg::CFG_CANVAS_WIDTH, rre_pkg::CFG_CANVAS_HEIGHT,
                rre_pkg::CFG_BACKGROUND, CFG_SPARE};
        val = '{rre_pkg::CFG_DAT_W'(width), rre_pkg::CFG_DAT_W'(height),
                rre_pkg::CFG_DAT_W'(bg), rre_pkg::CFG_DAT_W'($urandom)};
        for (k = 0; k < 4; k++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data  <= val[k];
            @(posedge i_clk);
            while (o_cfg_ready !== 1'b1) @(posedge i_clk);
            shadow_config(idx[k], val[k]);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // clear first so no read ever lands on an unwritten pixel; end on a read
    // so the block is idle once its result is back
    task automatic run_canvas_phase(input int width, input int height, input int bg,
                                    input int count, input int clear_pct,
                                    input int big_pct);
        int k;
        program_canvas(width, height, bg);
        send_command(as_action(rand_command(0, 0), rre_pkg::ACT_CLEAR));
        for (k = 0; k < count; k++)
            send_command(rand_command(clear_pct, big_pct));
        send_command(as_action(rand_command(0, 0), rre_pkg::ACT_READ));
        release_input();
        wait_drained();
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------
    task automatic test_directed_shapes();
        // runs on the reset configuration: 256 x 256, space background
        send_command(as_action(rand_command(0, 0), rre_pkg::ACT_CLEAR));
        send_command(make_read(0, 0));
        send_command(make_read(255, 255));
        send_command(make_draw(1, 1, 1, 1, 1, 8'hFF));
        send_command(make_draw(0, 3, 3, 5, 4, CHAR_R));
        send_command(make_draw(1, -512, -512, 511, 511, 8'h11));  // wholly off canvas
        send_command(make_draw(1, 10, 10, 0, 5, 8'hAA));          // zero width
        send_command(make_draw(0, 10, 10, 5, 0, 8'hAA));          // zero height
        send_command(make_draw(0, 250, 250, 511, 511, 8'h00));    // clipped right and below
        send_command(make_draw(1, 511, 511, 3, 3, 8'h55));        // beyond the far corner
        send_command(make_draw(0, 1, 1, 256, 256, 8'h7E));        // full canvas outline
        send_command(make_draw(1, -5, -5, WIDE_RECT, 8, 8'h01));  // clipped left, right and above
        send_command(as_action(rand_command(0, 0), ACT_NONE));
        send_command(make_draw(0, 100, 100, 1, 1, 8'hC3));
        send_command(make_draw(0, 120, 60, 2, 7, 8'h3C));
        send_command(make_read(0, 0));
        send_command(make_read(2, 4));
        send_command(make_read(4, 3));
        send_command(make_read(255, 200));
        send_command(make_read(249, 249));
        send_command(make_read(250, 250));
        send_command(make_read(99, 99));
        send_command(make_read(120, 62));
        send_command(make_read(0, 1));
        send_command(make_read(255, 255));
        release_input();
        wait_drained();
    endtask

    task automatic test_full_canvas();
        run_canvas_phase(256, 256, $urandom_range(0, 511), 250, 1, 0);
    endtask

    task automatic test_minimum_canvas();
        run_canvas_phase(1, 1, 0, 200, 6, 15);
    endtask

    task automatic test_empty_canvas();
        // zero columns: nothing is written, every read answers the background
        run_canvas_phase(0, 5, 9'h1FF, 100, 6, 15);
    endtask

    task automatic test_oversize_canvas();
        run_canvas_phase(511, 3, $urandom_range(0, 511), 300, 5, 15);
        run_canvas_phase(2, 400, $urandom_range(0, 511), 300, 5, 15);
    endtask

    task automatic test_steady_stream();
        steady = 1'b1;
        run_canvas_phase(17, 40, 255, 350, 4, 10);
        steady = 1'b0;
    endtask

    task automatic test_output_backpressure();
        t_command cmd;
        int k;
        program_canvas(12, 12, $urandom_range(0, 511));
        send_command(as_action(rand_command(0, 0), rre_pkg::ACT_CLEAR));
        hold_req = 1'b1;
        // keep offering beats while the sink is held off so the block backs up
        for (k = 0; k < 30; k++) begin
            cmd = rand_command(0, 10);
            if ($urandom_range(3) != 0)
                cmd.action = rre_pkg::ACT_READ;
            send_command(cmd);
        end
        send_command(as_action(rand_command(0, 0), rre_pkg::ACT_READ));
        release_input();
        wait_drained();
    endtask

    task automatic test_mixed_canvases();
        int k;
        for (k = 0; k < 3; k++)
            run_canvas_phase($urandom_range(1, 64), $urandom_range(1, 64),
                             $urandom_range(0, 511), 115, 4, 15);
    endtask

    // ------------------------------------------------------------------
    // result side
    // ------------------------------------------------------------------
    initial begin : result_sink
        int held;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req) begin
                hold_req = 1'b0;
                held     = HOLD_CYCLES;
            end
            if (held > 0) begin
                held--;
                i_out_ready <= 1'b0;
            end else if (steady) begin
                i_out_ready <= 1'b1;
            end else begin
                i_out_ready <= ($urandom_range(99) >= IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pixel_expect_q.size() == 0) begin
                $error("pixel_char: expected nothing, got %0d", o_pixel_char);
                mismatch_count++;
            end else begin
                pixel_want = pixel_expect_q.pop_front();
                pixels_checked++;
                if (o_pixel_char !== pixel_want) begin
                    $error("pixel_char: expected %0d, got %0d", pixel_want, o_pixel_char);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_shapes();
        test_full_canvas();
        test_minimum_canvas();
        test_empty_canvas();
        test_oversize_canvas();
        test_steady_stream();
        test_output_backpressure();
        test_mixed_canvases();

        wait_drained();
        $display("Covered %0d clears, %0d draws and %0d reads across %0d register writes.",
                 clears_sent, draws_sent, reads_sent, cfg_writes);
        $display("Compared %0d pixels in %0d cycles, %0d mismatches.",
                 pixels_checked, cycle_count, mismatch_count);
        if (mismatch_count == 0 && pixel_expect_q.size() == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[rectangle_raster_engine.f]
hdl/rre_pkg.sv
hdl/rre_ctrl.sv
hdl/rre_dp.sv
hdl/rectangle_raster_engine.sv
hdl/rre_checker.sv
tb/sv/rectangle_raster_engine_tb.sv
